// ===== hw/rtl/fpba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared types, codes and defaults of the fit-policy block allocator.
// ----------------------------------------------------------------------------
package fpba_pkg;

    // Default table geometry
    localparam int DEF_MAX_BLOCKS = 16;
    localparam int DEF_SIZE_BITS  = 16;

    // Fixed field widths of the channels
    localparam int OP_W         = 1;
    localparam int LOAD_INDEX_W = 4;
    localparam int SIZE_W       = 16;
    localparam int BLOCK_NUM_W  = 4;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;
    localparam int POLICY_W    = 2;
    localparam int BCOUNT_W    = 5;

    localparam logic [CFG_INDEX_W-1:0] REG_POLICY      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_COUNT = 2'd1;

    localparam logic [BCOUNT_W-1:0] BCOUNT_RESET = 5'd16;

    typedef enum logic [POLICY_W-1:0] {
        POL_FIRST = 2'd0,
        POL_BEST  = 2'd1,
        POL_NEXT  = 2'd2,
        POL_WORST = 2'd3
    } policy_t;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 1'b0,
        OP_ALLOC = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CLEAR,
        ST_DONE
    } state_t;

endpackage

// ===== hw/rtl/fpba_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_if
// Valid/ready channels of the allocator: request words in, grant words out.
// ----------------------------------------------------------------------------
interface fpba_req_if;
    logic                                valid;
    logic                                ready;
    logic [fpba_pkg::OP_W-1:0]           operation;
    logic [fpba_pkg::LOAD_INDEX_W-1:0]   load_index;
    logic [fpba_pkg::SIZE_W-1:0]         size;

    modport source (output valid, output operation, output load_index, output size,
                    input ready);
    modport sink   (input valid, input operation, input load_index, input size,
                    output ready);
endinterface

interface fpba_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                granted;
    logic [fpba_pkg::BLOCK_NUM_W-1:0]    block_number;

    modport source (output valid, output granted, output block_number, input ready);
    modport sink   (input valid, input granted, input block_number, output ready);
endinterface

// ===== hw/rtl/fpba_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fpba_ram #(
    parameter int WIDTH = fpba_pkg::DEF_SIZE_BITS,
    parameter int DEPTH = fpba_pkg::DEF_MAX_BLOCKS
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/fit_policy_block_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_policy_block_allocator
// Free-block table with first, best, next and worst fit allocation.
//
// The block holds a table of MAX_BLOCKS free sizes in a RAM. A load word
// writes one entry (ignored when load_index is past the table), rewinds the
// next-fit pointer to 0, leaves the block idle and gives no grant word. An
// allocate word starts a scan of the first min(block_count, MAX_BLOCKS)
// entries with one shared comparator, one entry per cycle, under the policy
// register: first fit, best fit (smallest fitting size), worst fit (largest
// fitting size) with ties to the lower index, or next fit, a single circular
// pass starting at the last granted index (0 if that is past the count). The
// chosen entry is cleared to zero and one grant word goes out; block_number is
// 0 when nothing fits. First and next fit stop the scan at the first hit;
// a hit then passes through the clear state and the done state, which loads
// the grant word into the output register, while a miss skips the clear
// state and a zero block count goes from idle straight to the done state.
// The RAM read port, one entry per cycle, paces the scan. A grant word that
// finds the output register still full holds the scan sequencer until it
// drains. The request side is not ready during a scan, but a finished grant
// waits in the output register while new words are taken. The table resets
// to all zero through one valid flop per entry, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator #(
    parameter int MAX_BLOCKS = fpba_pkg::DEF_MAX_BLOCKS,
    parameter int SIZE_BITS  = fpba_pkg::DEF_SIZE_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [fpba_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [fpba_pkg::CFG_DATA_W-1:0]    cfg_data,
    fpba_req_if.sink                           req,
    fpba_rsp_if.source                         rsp
);

    // Index and count widths follow the table depth
    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_W = (CNT_W > fpba_pkg::BCOUNT_W) ? CNT_W : fpba_pkg::BCOUNT_W;
    localparam int LX_W  = (IDX_W > fpba_pkg::LOAD_INDEX_W) ? IDX_W : fpba_pkg::LOAD_INDEX_W;
    localparam int BX_W  = (IDX_W > fpba_pkg::BLOCK_NUM_W) ? IDX_W : fpba_pkg::BLOCK_NUM_W;
    localparam int SX_W  = (SIZE_BITS > fpba_pkg::SIZE_W) ? SIZE_BITS : fpba_pkg::SIZE_W;

    // Configuration registers
    fpba_pkg::policy_t               policy_reg;
    logic [fpba_pkg::BCOUNT_W-1:0]   block_count_reg;

    // Sequencer state and datapath registers
    fpba_pkg::state_t  state_reg,      state_next;
    logic [IDX_W-1:0]  next_start_reg, next_start_next;
    logic [MAX_BLOCKS-1:0] valid_reg,  valid_next;
    logic [SIZE_BITS-1:0] req_size_reg, req_size_next;
    logic [CNT_W-1:0]  cnt_reg,        cnt_next;
    logic [CNT_W-1:0]  step_reg,       step_next;
    logic [IDX_W-1:0]  pos_reg,        pos_next;
    logic [IDX_W-1:0]  cmp_pos_reg,    cmp_pos_next;
    logic              cmp_live_reg,   cmp_live_next;
    logic [IDX_W-1:0]  pick_reg,       pick_next;
    logic [SIZE_BITS-1:0] pick_size_reg, pick_size_next;
    logic              found_reg,      found_next;
    logic              rsp_valid_reg,  rsp_valid_next;
    logic              granted_reg,    granted_next;
    logic [fpba_pkg::BLOCK_NUM_W-1:0] number_reg, number_next;

    // RAM port
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [SIZE_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [IDX_W-1:0]     ram_raddr;
    logic [SIZE_BITS-1:0] ram_rdata;

    // Decoded request fields
    logic                 req_fire;
    logic [LX_W-1:0]      load_index_ext;
    logic [IDX_W-1:0]     load_addr;
    logic                 load_in_range;
    logic [SIZE_BITS-1:0] size_trunc;
    logic [CNT_W-1:0]     cnt_eff;
    logic [IDX_W-1:0]     start_pos;

    // Shared compare unit
    logic [SIZE_BITS-1:0] entry;
    logic                 fits;
    logic                 better;

    // Step one place around the circular window of cnt entries
    function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] pos,
                                                   input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] inc;
        inc = CNT_W'(pos) + CNT_W'(1);
        if (inc == cnt)
        begin
            return '0;
        end
        return inc[IDX_W-1:0];
    endfunction

    fpba_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Config writes land at once; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg      <= fpba_pkg::POL_FIRST;
            block_count_reg <= fpba_pkg::BCOUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fpba_pkg::REG_POLICY:
                begin
                    policy_reg <= fpba_pkg::policy_t'(cfg_data[fpba_pkg::POLICY_W-1:0]);
                end
                fpba_pkg::REG_BLOCK_COUNT:
                begin
                    block_count_reg <= cfg_data[fpba_pkg::BCOUNT_W-1:0];
                end
                default:
                begin
                    block_count_reg <= block_count_reg;
                end
            endcase
        end
    end

    // Field decode
    assign req_fire       = req.valid && req.ready;
    assign load_index_ext = LX_W'(req.load_index);
    assign load_addr      = load_index_ext[IDX_W-1:0];
    assign load_in_range  = (int'(req.load_index) < MAX_BLOCKS);
    assign size_trunc     = SIZE_BITS'(SX_W'(req.size));
    assign cnt_eff        = (CMP_W'(block_count_reg) > CMP_W'(MAX_BLOCKS))
                            ? CNT_W'(MAX_BLOCKS)
                            : CNT_W'(block_count_reg);
    // Next fit starts at the last grant, or at 0 when that index is stale
    assign start_pos      = ((policy_reg == fpba_pkg::POL_NEXT) &&
                             (CNT_W'(next_start_reg) < cnt_eff)) ? next_start_reg : '0;

    // Entries never written (or cleared) read as zero
    assign entry  = valid_reg[cmp_pos_reg] ? ram_rdata : '0;
    assign fits   = (entry >= req_size_reg);
    assign better = !found_reg ||
                    ((policy_reg == fpba_pkg::POL_BEST)  && (entry < pick_size_reg)) ||
                    ((policy_reg == fpba_pkg::POL_WORST) && (entry > pick_size_reg));

    // Request side takes words only while idle
    assign req.ready = (state_reg == fpba_pkg::ST_IDLE);

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.granted      = granted_reg;
    assign rsp.block_number = number_reg;

    // Read address: start entry when a scan launches, then the walking pointer
    assign ram_re    = (state_reg == fpba_pkg::ST_SCAN) ||
                       (req_fire && (req.operation == fpba_pkg::OP_ALLOC));
    assign ram_raddr = (state_reg == fpba_pkg::ST_IDLE) ? start_pos : pos_reg;

    // Only load words write the RAM; grants clear the valid flop instead
    assign ram_we    = req_fire && (req.operation == fpba_pkg::OP_LOAD) && load_in_range;
    assign ram_waddr = load_addr;
    assign ram_wdata = size_trunc;

    // Sequencer next state and datapath
    always_comb
    begin
        logic [BX_W-1:0] pick_ext;

        state_next      = state_reg;
        next_start_next = next_start_reg;
        valid_next      = valid_reg;
        req_size_next   = req_size_reg;
        cnt_next        = cnt_reg;
        step_next       = step_reg;
        pos_next        = pos_reg;
        cmp_pos_next    = cmp_pos_reg;
        cmp_live_next   = 1'b0;
        pick_next       = pick_reg;
        pick_size_next  = pick_size_reg;
        found_next      = found_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        granted_next    = granted_reg;
        number_next     = number_reg;
        pick_ext        = BX_W'(pick_reg);

        case (state_reg)
            fpba_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.operation == fpba_pkg::OP_LOAD)
                    begin
                        if (load_in_range)
                        begin
                            valid_next[load_addr] = 1'b1;
                        end
                        next_start_next = '0;
                    end
                    else
                    begin
                        req_size_next = size_trunc;
                        cnt_next      = cnt_eff;
                        step_next     = '0;
                        found_next    = 1'b0;
                        pick_next     = '0;
                        cmp_pos_next  = start_pos;
                        pos_next      = wrap_next(start_pos, cnt_eff);
                        if (cnt_eff == '0)
                        begin
                            state_next = fpba_pkg::ST_DONE;
                        end
                        else
                        begin
                            cmp_live_next = 1'b1;
                            state_next    = fpba_pkg::ST_SCAN;
                        end
                    end
                end
            end

            fpba_pkg::ST_SCAN:
            begin
                // Keep the read pipeline full one entry ahead
                cmp_pos_next  = pos_reg;
                pos_next      = wrap_next(pos_reg, cnt_reg);
                cmp_live_next = 1'b1;
                if (cmp_live_reg)
                begin
                    step_next = step_reg + CNT_W'(1);
                    if (fits && better)
                    begin
                        found_next     = 1'b1;
                        pick_next      = cmp_pos_reg;
                        pick_size_next = entry;
                    end
                    if (fits && ((policy_reg == fpba_pkg::POL_FIRST) ||
                                 (policy_reg == fpba_pkg::POL_NEXT)))
                    begin
                        // First hit wins: stop the scan here
                        cmp_live_next = 1'b0;
                        state_next    = fpba_pkg::ST_CLEAR;
                    end
                    else if (step_reg == cnt_reg - CNT_W'(1))
                    begin
                        cmp_live_next = 1'b0;
                        state_next    = found_next ? fpba_pkg::ST_CLEAR : fpba_pkg::ST_DONE;
                    end
                end
            end

            fpba_pkg::ST_CLEAR:
            begin
                // Hand out the whole block: its free size drops to zero
                valid_next[pick_reg] = 1'b0;
                if (policy_reg == fpba_pkg::POL_NEXT)
                begin
                    next_start_next = pick_reg;
                end
                state_next = fpba_pkg::ST_DONE;
            end

            fpba_pkg::ST_DONE:
            begin
                // Hold until the output register is free
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    granted_next   = found_reg;
                    number_next    = found_reg ? pick_ext[fpba_pkg::BLOCK_NUM_W-1:0] : '0;
                    state_next     = fpba_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = fpba_pkg::ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fpba_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_start_reg <= '0;
            valid_reg      <= '0;
            cmp_live_reg   <= 1'b0;
            found_reg      <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            step_reg       <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            next_start_reg <= next_start_next;
            valid_reg      <= valid_next;
            cmp_live_reg   <= cmp_live_next;
            found_reg      <= found_next;
            rsp_valid_reg  <= rsp_valid_next;
            step_reg       <= step_next;
            cnt_reg        <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_size_reg  <= req_size_next;
        pos_reg       <= pos_next;
        cmp_pos_reg   <= cmp_pos_next;
        pick_reg      <= pick_next;
        pick_size_reg <= pick_size_next;
        granted_reg   <= granted_next;
        number_reg    <= number_next;
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // The scan never walks past the searched window
    a_scan_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fpba_pkg::ST_SCAN) |->
            ((step_reg < cnt_reg) && (CNT_W'(cmp_pos_reg) < cnt_reg)))
        else $error("scan pointer outside the block window");

    // Only a found block is ever cleared
    a_clear_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fpba_pkg::ST_CLEAR) |-> found_reg)
        else $error("clear without a chosen block");

    // A cleared block reads as empty afterwards
    a_clear_takes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fpba_pkg::ST_CLEAR) |=> !valid_reg[$past(pick_reg)])
        else $error("granted block not cleared");

    // A new grant word never overwrites one still waiting
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp.ready) |=> (rsp_valid_reg && $stable(number_reg)))
        else $error("pending grant word lost");

endmodule
